// File: hdl/wcp_pkg.sv
// wcp_pkg: shared widths, result record and pixel mask helper for the
// waveform column plotter. No dependencies.
`timescale 1ns / 1ps

package wcp_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int ROW_W    = 5;
  localparam int PIX_W    = 32;
  localparam int COL_W    = 6;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // default frame width in columns
  localparam int NUM_COLUMNS_DEF = 64;

  // rows must jump by more than this before the gap is filled
  localparam logic [ROW_W:0] GAP_LIMIT = 6'd4;

  // one finished display column
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixels;
    logic             last_column;
  } wcp_result_t;

  // mask with bits lo..hi set, lo <= hi
  function automatic logic [PIX_W-1:0] range_mask(input logic [ROW_W-1:0] lo,
                                                  input logic [ROW_W-1:0] hi);
    logic [PIX_W-1:0] ones;
    ones = '1;
    return (ones >> (ROW_W'(PIX_W - 1) - hi)) & (ones << lo);
  endfunction

endpackage

// File: hdl/wcp_column_calc.sv
// wcp_column_calc: turns a sample pair into a display row and the column's
// pixel mask, including the vertical gap fill. Depends on wcp_pkg.
`timescale 1ns / 1ps

module wcp_column_calc
  import wcp_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] first_sample,
  input  logic signed [SAMPLE_W-1:0] second_sample,
  input  logic        [ROW_W-1:0]    prev_row,
  input  logic                       fill_en,
  output logic        [ROW_W-1:0]    row,
  output logic        [PIX_W-1:0]    pixels
);

  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   sum_adj;
  logic signed [SAMPLE_W-1:0] mean;
  logic        [SAMPLE_W-1:0] level;
  logic        [ROW_W:0]      row_x;
  logic        [ROW_W:0]      prev_x;

  // mean truncated toward zero: bias negative sums by one before the shift
  assign pair_sum = {first_sample[SAMPLE_W-1], first_sample}
                  + {second_sample[SAMPLE_W-1], second_sample};
  assign sum_adj  = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
  assign mean     = sum_adj[SAMPLE_W:1];

  // offset by 512 is a flip of the sign bit; the level always fits 0..1023,
  // so 31 - level/32 stays in range and needs no clamp
  assign level = {~mean[SAMPLE_W-1], mean[SAMPLE_W-2:0]};
  assign row   = ~level[SAMPLE_W-1 -: ROW_W];

  assign row_x  = {1'b0, row};
  assign prev_x = {1'b0, prev_row};

  // lit row plus the gap toward the previous row on a fill_en jump over GAP_LIMIT
  always_comb begin
    pixels = '0;
    pixels[row] = 1'b1;
    if (fill_en) begin
      if (row_x > prev_x + GAP_LIMIT) begin
        pixels = pixels | range_mask(prev_row + ROW_W'(1), row);
      end else if (row_x + GAP_LIMIT < prev_x) begin
        pixels = pixels | range_mask(row, prev_row - ROW_W'(1));
      end
    end
  end

endmodule

// File: hdl/waveform_column_plotter.sv
// waveform_column_plotter: top level, pairs samples, tracks the column
// count and buffers results in an output register plus skid register.
// Depends on wcp_pkg and wcp_column_calc.
//
//   channel  dir  tdata                          tuser        tlast
//   in_      in   sample[9:0]                    frame_start  -
//   out_     out  column[5:0], pixels[37:6]      -            last_column
//
// One sample is taken per cycle while in_tready is high; every second sample
// yields a registered column, computed in a single pass from the sample and
// the held state. A stalled output fills the skid register; in_tready drops
// only when both result registers are full. rst_n is synchronous and clears
// the pairing phase, column count, previous row and valid flags.
`timescale 1ns / 1ps

module waveform_column_plotter
  import wcp_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] sample, rest zero
  input  logic                   in_tuser,   // [0] frame_start
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] column, [37:6] pixels
  output logic                   out_tlast   // last_column
);

  localparam int CNT_W = (NUM_COLUMNS > 2) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_COLUMNS - 1);

  logic [SAMPLE_W-1:0] held_r,  held_nxt;
  logic                phase_r, phase_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ROW_W-1:0]    prev_r,  prev_nxt;

  wcp_result_t out_r,   out_nxt;
  wcp_result_t skid_r,  skid_nxt;
  logic        out_valid_r,  out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  logic                in_req;
  logic                cur_phase;
  logic [CNT_W-1:0]    cur_count;
  logic                push;
  logic                pop;
  logic                is_last;
  logic [ROW_W-1:0]    new_row;
  logic [PIX_W-1:0]    new_pixels;
  wcp_result_t         new_res;

  assign in_tready = ~skid_valid_r;
  assign in_req    = in_tvalid & in_tready;

  // frame start drops a half pair and restarts the count
  assign cur_phase = in_tuser ? 1'b0 : phase_r;
  assign cur_count = in_tuser ? '0 : count_r;
  assign is_last   = (cur_count >= LAST_CNT);
  assign push      = in_req & cur_phase;
  assign pop       = out_valid_r & out_tready;

  wcp_column_calc u_calc (
    .first_sample  (held_r),
    .second_sample (in_tdata[SAMPLE_W-1:0]),
    .prev_row      (prev_r),
    .fill_en       (cur_count > CNT_W'(1)),
    .row           (new_row),
    .pixels        (new_pixels)
  );

  assign new_res.column      = COL_W'(cur_count);
  assign new_res.pixels      = new_pixels;
  assign new_res.last_column = is_last;

  // pairing state and column count
  always_comb begin
    held_nxt  = held_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    if (in_req) begin
      if (!cur_phase) begin
        held_nxt  = in_tdata[SAMPLE_W-1:0];
        phase_nxt = 1'b1;
        count_nxt = cur_count;
      end else begin
        phase_nxt = 1'b0;
        prev_nxt  = new_row;
        count_nxt = is_last ? '0 : cur_count + CNT_W'(1);
      end
    end
  end

  // output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = new_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = new_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      phase_r      <= 1'b0;
      count_r      <= '0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      prev_r       <= prev_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - PIX_W - COL_W){1'b0}}, out_r.pixels, out_r.column};
  assign out_tlast  = out_r.last_column;

endmodule
